// ----- rtl/sbie_pkg.sv -----
// ----------------------------------------------------------------------------
// sbie_pkg
// Shared types, opcodes, status codes and default sizes of the executor.
// ----------------------------------------------------------------------------
package sbie_pkg;

  localparam int DATA_DEPTH_DEF  = 65536;
  localparam int STACK_WORDS_DEF = 2048;
  localparam int CALL_FRAMES_DEF = 128;

  localparam int NUM_REGS = 8;
  localparam int REG_AW   = 3;
  localparam int WORD_W   = 16;
  localparam int PC_W     = 24;
  localparam int EA_W     = 26;

  typedef logic [4:0] op_t;
  localparam op_t OP_HLT    = 5'd0;
  localparam op_t OP_JMP    = 5'd1;
  localparam op_t OP_CJMP   = 5'd2;
  localparam op_t OP_OJMP   = 5'd3;
  localparam op_t OP_CALL   = 5'd4;
  localparam op_t OP_RET    = 5'd5;
  localparam op_t OP_PUSH   = 5'd6;
  localparam op_t OP_POP    = 5'd7;
  localparam op_t OP_LOADB  = 5'd8;
  localparam op_t OP_LOADW  = 5'd9;
  localparam op_t OP_STOREB = 5'd10;
  localparam op_t OP_STOREW = 5'd11;
  localparam op_t OP_LOADI  = 5'd12;
  localparam op_t OP_NOP    = 5'd13;
  localparam op_t OP_IN     = 5'd14;
  localparam op_t OP_OUT    = 5'd15;
  localparam op_t OP_ADD    = 5'd16;
  localparam op_t OP_ADDI   = 5'd17;
  localparam op_t OP_SUB    = 5'd18;
  localparam op_t OP_SUBI   = 5'd19;
  localparam op_t OP_MUL    = 5'd20;
  localparam op_t OP_DIV    = 5'd21;
  localparam op_t OP_AND    = 5'd22;
  localparam op_t OP_OR     = 5'd23;
  localparam op_t OP_NOR    = 5'd24;
  localparam op_t OP_NOTB   = 5'd25;
  localparam op_t OP_SAL    = 5'd26;
  localparam op_t OP_SAR    = 5'd27;
  localparam op_t OP_EQU    = 5'd28;
  localparam op_t OP_LT     = 5'd29;
  localparam op_t OP_LTE    = 5'd30;
  localparam op_t OP_NOTC   = 5'd31;

  typedef logic [3:0] status_t;
  localparam status_t ST_OK      = 4'd0;
  localparam status_t ST_HALT    = 4'd1;
  localparam status_t ST_ZDEST   = 4'd2;
  localparam status_t ST_BADREG  = 4'd3;
  localparam status_t ST_PORT    = 4'd4;
  localparam status_t ST_DIV0    = 4'd5;
  localparam status_t ST_OVF     = 4'd6;
  localparam status_t ST_UNDER   = 4'd7;
  localparam status_t ST_FRAME   = 4'd8;
  localparam status_t ST_RANGE   = 4'd9;
  localparam status_t ST_STOPPED = 4'd10;

  localparam logic [7:0] PORT_IN  = 8'd0;
  localparam logic [7:0] PORT_OUT = 8'd15;

  typedef struct packed {
    logic                we;
    logic [REG_AW-1:0]   addr;
    logic [WORD_W-1:0]   data;
  } rf_wr_t;

  typedef struct packed {
    logic                done;
    logic                ovf;
    logic [WORD_W-1:0]   quo;
  } div_res_t;

endpackage

// ----- rtl/sbie_if.sv -----
// ----------------------------------------------------------------------------
// sbie_if
// Request and result channels of the executor.
// ----------------------------------------------------------------------------
interface sbie_in_if;
  logic              valid;
  logic              ready;
  logic              func;
  logic [31:0]       instr;
  logic signed [8:0] in_char;
  logic [15:0]       mem_addr;
  logic [7:0]        mem_byte;

  modport source (output valid, func, instr, in_char, mem_addr, mem_byte, input ready);
  modport sink   (input valid, func, instr, in_char, mem_addr, mem_byte, output ready);
endinterface

interface sbie_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [23:0] next_pc;
  logic        out_valid;
  logic [7:0]  out_char;

  modport source (output valid, status, next_pc, out_valid, out_char, input ready);
  modport sink   (input valid, status, next_pc, out_valid, out_char, output ready);
endinterface

// ----- rtl/sbie_rf.sv -----
// ----------------------------------------------------------------------------
// sbie_rf
// Register file memory: two registered read ports, one write port, and a
// valid bit per register so that unwritten registers read as zero.
// ----------------------------------------------------------------------------
module sbie_rf
  import sbie_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [REG_AW-1:0] raddr_a,
  input  logic [REG_AW-1:0] raddr_b,
  output logic [WORD_W-1:0] rdata_a,
  output logic [WORD_W-1:0] rdata_b,
  input  rf_wr_t            wr
);

  logic [WORD_W-1:0]   mem [NUM_REGS];
  logic [NUM_REGS-1:0] valid;
  logic [WORD_W-1:0]   rd_a, rd_b;
  logic                vl_a, vl_b;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vl_a  <= 1'b0;
      vl_b  <= 1'b0;
    end else begin
      if (wr.we) begin
        valid[wr.addr] <= 1'b1;
      end
      vl_a <= valid[raddr_a];
      vl_b <= valid[raddr_b];
    end
  end

  assign rdata_a = vl_a ? rd_a : '0;
  assign rdata_b = vl_b ? rd_b : '0;

endmodule

// ----- rtl/sbie_div.sv -----
// ----------------------------------------------------------------------------
// sbie_div
// Signed 16-bit divider, restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbie_div
  import sbie_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output div_res_t          res
);

  localparam int CNT_W = $clog2(WORD_W + 1);

  logic              run;
  logic [CNT_W-1:0]  cnt;
  logic              neg;
  logic [WORD_W-1:0] den;
  logic [WORD_W-1:0] quo;
  logic [WORD_W:0]   rem;
  logic              done;
  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;

  assign shifted = {rem[WORD_W-1:0], quo[WORD_W-1]};
  assign diff    = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(WORD_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
      quo <= dividend[WORD_W-1] ? -dividend : dividend;
      den <= divisor[WORD_W-1] ? -divisor : divisor;
      rem <= '0;
    end else if (run) begin
      if (!diff[WORD_W]) begin
        rem <= diff;
        quo <= {quo[WORD_W-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[WORD_W-2:0], 1'b0};
      end
    end
  end

  // only +32768 can leave the signed range
  assign res.done = done;
  assign res.ovf  = !neg && quo[WORD_W-1];
  assign res.quo  = neg ? -quo : quo;

endmodule

// ----- rtl/sixteen_bit_instruction_executor_top.sv -----
// ----------------------------------------------------------------------------
// sixteen_bit_instruction_executor_top
// Executes one instruction or memory preload per request on a 16-bit machine.
// ----------------------------------------------------------------------------
// A preload or halted request goes straight to the result; an instruction
// reads its operands and executes, and memory access, CALL/RET (copy of eight
// registers through the frame memory) and DIV (one quotient bit per cycle) go on.
// Throughput: one request at a time, the next accepted once the result is
// queued in the output register. Reset clears registers, PC, flags, stack
// pointers and halt; data, stack and frame memories hold garbage until written.
module sixteen_bit_instruction_executor_top
  import sbie_pkg::*;
#(
  parameter int DATA_DEPTH  = DATA_DEPTH_DEF,
  parameter int STACK_WORDS = STACK_WORDS_DEF,
  parameter int CALL_FRAMES = CALL_FRAMES_DEF
) (
  input  logic clk,
  input  logic rst,
  sbie_in_if.sink    in_ch,
  sbie_out_if.source out_ch
);

  localparam int AW   = $clog2(DATA_DEPTH);
  localparam int SA   = $clog2(STACK_WORDS);
  localparam int STW  = $clog2(STACK_WORDS + 1);
  localparam int FA   = $clog2(CALL_FRAMES);
  localparam int FTW  = $clog2(CALL_FRAMES + 1);
  localparam logic [EA_W-1:0] DD    = EA_W'(DATA_DEPTH);
  localparam logic [EA_W-1:0] DD_M1 = EA_W'(DATA_DEPTH - 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RD   = 9'b000000010,
    S_OPS  = 9'b000000100,
    S_EXEC = 9'b000001000,
    S_MEM  = 9'b000010000,
    S_DIV  = 9'b000100000,
    S_CALL = 9'b001000000,
    S_RET  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic [3:0] cnt, cnt_next;
  logic [PC_W-1:0] pc, pc_next;
  logic ovf, ovf_next, cy, cy_next, halted, halted_next;
  logic [STW-1:0] wt, wt_next;
  logic [FTW-1:0] ft, ft_next;

  logic [31:0] ir, ir_next;
  logic signed [8:0] inch, inch_next;
  logic [WORD_W-1:0] vd, vd_next, va, va_next, vb, vb_next, vg, vg_next;
  logic [AW-1:0] ea_q, ea_q_next;
  logic [7:0] lo, lo_next;
  status_t res_status, res_status_next;
  logic [PC_W-1:0] res_npc, res_npc_next;
  logic res_ov, res_ov_next;
  logic [7:0] res_oc, res_oc_next;

  logic o_valid, o_valid_next;
  status_t o_status;
  logic [PC_W-1:0] o_npc;
  logic o_ov;
  logic [7:0] o_oc;
  logic o_load;

  // register file
  logic [REG_AW-1:0] rf_ra, rf_rb;
  logic [WORD_W-1:0] rf_da, rf_db;
  rf_wr_t rf_wr;

  sbie_rf u_rf (
    .clk, .rst,
    .raddr_a (rf_ra), .raddr_b (rf_rb),
    .rdata_a (rf_da), .rdata_b (rf_db),
    .wr      (rf_wr)
  );

  // divider
  logic div_start;
  div_res_t div_res;

  sbie_div u_div (
    .clk, .rst,
    .start    (div_start),
    .dividend (va),
    .divisor  (vb),
    .res      (div_res)
  );

  // memories
  logic [7:0] dm [DATA_DEPTH];
  logic dm_we;
  logic [AW-1:0] dm_wa, dm_ra;
  logic [7:0] dm_wd, dm_q;

  logic [WORD_W-1:0] ws [STACK_WORDS];
  logic ws_we;
  logic [SA-1:0] ws_wa, ws_ra;
  logic [WORD_W-1:0] ws_q;

  logic [WORD_W-1:0] fr [CALL_FRAMES*8];
  logic fr_we;
  logic [FA+2:0] fr_wa, fr_ra;
  logic [WORD_W-1:0] fr_q;

  logic [PC_W+1:0] fp [CALL_FRAMES];
  logic fp_we;
  logic [FA-1:0] fp_wa, fp_ra;
  logic [PC_W+1:0] fp_q;

  always_ff @(posedge clk) begin
    if (dm_we) dm[dm_wa] <= dm_wd;
    dm_q <= dm[dm_ra];
  end

  always_ff @(posedge clk) begin
    if (ws_we) ws[ws_wa] <= vd;
    ws_q <= ws[ws_ra];
  end

  always_ff @(posedge clk) begin
    if (fr_we) fr[fr_wa] <= rf_da;
    fr_q <= fr[fr_ra];
  end

  always_ff @(posedge clk) begin
    if (fp_we) fp[fp_wa] <= {cy, ovf, pc};
    fp_q <= fp[fp_ra];
  end

  // instruction fields
  op_t op;
  logic [REG_AW-1:0] d;
  logic [3:0] r1, r2;
  logic [PC_W-1:0] addr, pc4;
  logic [WORD_W-1:0] imm;
  logic [7:0] port;

  assign op   = ir[31:27];
  assign d    = ir[26:24];
  assign r1   = ir[23:20];
  assign r2   = ir[19:16];
  assign addr = ir[23:0];
  assign imm  = ir[15:0];
  assign port = ir[7:0];
  assign pc4  = pc + PC_W'(4);

  // effective address
  logic [EA_W-1:0] g_sx, ea;
  logic is_word, is_mem, range_bad;

  assign g_sx    = {{(EA_W-WORD_W){vg[WORD_W-1]}}, vg};
  assign is_word = (op == OP_LOADW) || (op == OP_STOREW);
  assign is_mem  = (op == OP_LOADB) || (op == OP_STOREB) || is_word;
  assign ea      = {2'b00, addr} + (is_word ? {g_sx[EA_W-2:0], 1'b0} : g_sx);
  assign range_bad = ea[EA_W-1] || (is_word ? (ea >= DD_M1) : (ea >= DD));

  // error check
  logic needs_d, bad2, bad1;
  status_t err;

  assign needs_d = (op == OP_POP) || (op == OP_LOADW) || (op == OP_LOADI) ||
                   (op == OP_IN) || (op[4] && (op <= OP_SAR));
  assign bad2 = ((op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL) || (op == OP_DIV) ||
                 (op == OP_AND) || (op == OP_OR) || (op == OP_NOR) || (op == OP_SAL) ||
                 (op == OP_SAR)) && (r1[3] || r2[3]);
  assign bad1 = ((op == OP_NOTB) || (op == OP_EQU) || (op == OP_LT) || (op == OP_LTE))
                && r1[3];

  always_comb begin
    err = ST_OK;
    priority if (needs_d && (d == '0))                       err = ST_ZDEST;
    else if (bad2 || bad1)                                   err = ST_BADREG;
    else if ((op == OP_CALL) && (ft == FTW'(CALL_FRAMES)))   err = ST_FRAME;
    else if ((op == OP_PUSH) && (wt == STW'(STACK_WORDS)))   err = ST_OVF;
    else if ((op == OP_POP) && (wt == '0))                   err = ST_UNDER;
    else if (is_mem && range_bad)                            err = ST_RANGE;
    else if ((op == OP_IN) && (port != PORT_IN))             err = ST_PORT;
    else if ((op == OP_OUT) && (port != PORT_OUT))           err = ST_PORT;
    else if ((op == OP_DIV) && (vb == '0))                   err = ST_DIV0;
    else                                                     err = ST_OK;
  end

  // arithmetic
  logic [WORD_W:0] add_r, sub_r;
  logic [WORD_W+1:0] addi_r, subi_r;
  logic signed [2*WORD_W-1:0] mul_r;
  logic [3:0] amt;
  logic [WORD_W-1:0] sal_r, sar_r;

  assign add_r  = {va[WORD_W-1], va} + {vb[WORD_W-1], vb};
  assign sub_r  = {va[WORD_W-1], va} - {vb[WORD_W-1], vb};
  assign addi_r = {{2{vd[WORD_W-1]}}, vd} + {2'b00, imm};
  assign subi_r = {{2{vd[WORD_W-1]}}, vd} - {2'b00, imm};
  assign mul_r  = $signed(va) * $signed(vb);
  // saturate the amount to 0..15
  assign amt    = vb[WORD_W-1] ? 4'd0 : ((|vb[WORD_W-2:4]) ? 4'd15 : vb[3:0]);
  assign sal_r  = va << amt;
  assign sar_r  = WORD_W'($signed(va) >>> amt);

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    pc_next         = pc;
    ovf_next        = ovf;
    cy_next         = cy;
    halted_next     = halted;
    wt_next         = wt;
    ft_next         = ft;
    ir_next         = ir;
    inch_next       = inch;
    vd_next         = vd;
    va_next         = va;
    vb_next         = vb;
    vg_next         = vg;
    ea_q_next       = ea_q;
    lo_next         = lo;
    res_status_next = res_status;
    res_npc_next    = res_npc;
    res_ov_next     = res_ov;
    res_oc_next     = res_oc;

    rf_ra = '0;
    rf_rb = '0;
    rf_wr = '{we: 1'b0, addr: d, data: '0};
    dm_we = 1'b0;
    dm_wa = ea[AW-1:0];
    dm_wd = vd[7:0];
    dm_ra = ea[AW-1:0];
    ws_we = 1'b0;
    ws_wa = wt[SA-1:0];
    ws_ra = SA'(wt - 1'b1);
    fr_we = 1'b0;
    fr_wa = {ft[FA-1:0], 3'(cnt - 1'b1)};
    fr_ra = {ft[FA-1:0], cnt[2:0]};
    fp_we = 1'b0;
    fp_wa = ft[FA-1:0];
    fp_ra = FA'(ft - 1'b1);
    div_start = 1'b0;
    o_load = 1'b0;

    unique case (state)
      S_IDLE: begin
        rf_ra = in_ch.instr[26:24];
        rf_rb = in_ch.instr[22:20];
        if (in_ch.valid) begin
          ir_next      = in_ch.instr;
          inch_next    = in_ch.in_char;
          res_npc_next = pc;
          res_ov_next  = 1'b0;
          res_oc_next  = '0;
          if (in_ch.func) begin
            dm_wa = AW'(in_ch.mem_addr);
            dm_wd = in_ch.mem_byte;
            dm_we = EA_W'(in_ch.mem_addr) < DD;
            res_status_next = ST_OK;
            state_next = S_DONE;
          end else if (halted) begin
            res_status_next = ST_STOPPED;
            state_next = S_DONE;
          end else begin
            state_next = S_RD;
          end
        end
      end

      S_RD: begin
        vd_next = rf_da;
        va_next = rf_db;
        rf_ra = ir[18:16];
        rf_rb = REG_AW'(NUM_REGS - 1);
        state_next = S_OPS;
      end

      S_OPS: begin
        vb_next = rf_da;
        vg_next = rf_db;
        state_next = S_EXEC;
      end

      S_EXEC: begin
        res_status_next = ST_OK;
        res_npc_next    = pc4;
        pc_next         = pc4;
        state_next      = S_DONE;
        cnt_next        = '0;
        ea_q_next       = AW'(ea + 1'b1);
        if (err != ST_OK) begin
          // fault: no effect but halt, stay at this instruction
          res_status_next = err;
          res_npc_next    = pc;
          pc_next         = pc;
          halted_next     = 1'b1;
        end else begin
          unique case (op)
            OP_HLT: begin
              res_status_next = ST_HALT;
              halted_next     = 1'b1;
            end
            OP_JMP: begin
              res_npc_next = addr;
              pc_next      = addr;
            end
            OP_CJMP: if (cy) begin
              res_npc_next = addr;
              pc_next      = addr;
            end
            OP_OJMP: if (ovf) begin
              res_npc_next = addr;
              pc_next      = addr;
            end
            OP_CALL: begin
              fp_we        = 1'b1;
              res_npc_next = addr;
              pc_next      = pc;
              state_next   = S_CALL;
            end
            OP_RET: begin
              if (ft == '0) begin
                res_status_next = ST_HALT;
                halted_next     = 1'b1;
              end else begin
                ft_next    = ft - 1'b1;
                pc_next    = pc;
                state_next = S_RET;
              end
            end
            OP_PUSH: begin
              ws_we   = 1'b1;
              wt_next = wt + 1'b1;
            end
            OP_POP: begin
              wt_next    = wt - 1'b1;
              pc_next    = pc;
              state_next = S_MEM;
            end
            OP_STOREB: dm_we = 1'b1;
            OP_LOADB, OP_LOADW, OP_STOREW: begin
              dm_we      = (op == OP_STOREW);
              pc_next    = pc;
              state_next = S_MEM;
            end
            OP_LOADI: rf_wr = '{we: 1'b1, addr: d, data: imm};
            OP_NOP: ;
            OP_IN: rf_wr = '{we: 1'b1, addr: d,
                             data: {{8{inch[8]}}, inch[7:0]}};
            OP_OUT: begin
              res_ov_next = 1'b1;
              res_oc_next = vd[7:0];
            end
            OP_ADD: begin
              ovf_next = add_r[WORD_W] != add_r[WORD_W-1];
              rf_wr = '{we: 1'b1, addr: d, data: add_r[WORD_W-1:0]};
            end
            OP_ADDI: begin
              ovf_next = !((addi_r[WORD_W+1:WORD_W-1] == '0) ||
                           (addi_r[WORD_W+1:WORD_W-1] == '1));
              rf_wr = '{we: 1'b1, addr: d, data: addi_r[WORD_W-1:0]};
            end
            OP_SUB: begin
              ovf_next = sub_r[WORD_W] != sub_r[WORD_W-1];
              rf_wr = '{we: 1'b1, addr: d, data: sub_r[WORD_W-1:0]};
            end
            OP_SUBI: begin
              ovf_next = !((subi_r[WORD_W+1:WORD_W-1] == '0) ||
                           (subi_r[WORD_W+1:WORD_W-1] == '1));
              rf_wr = '{we: 1'b1, addr: d, data: subi_r[WORD_W-1:0]};
            end
            OP_MUL: begin
              ovf_next = !((mul_r[2*WORD_W-1:WORD_W-1] == '0) ||
                           (mul_r[2*WORD_W-1:WORD_W-1] == '1));
              rf_wr = '{we: 1'b1, addr: d, data: mul_r[WORD_W-1:0]};
            end
            OP_DIV: begin
              div_start  = 1'b1;
              pc_next    = pc;
              state_next = S_DIV;
            end
            OP_AND:  rf_wr = '{we: 1'b1, addr: d, data: va & vb};
            OP_OR:   rf_wr = '{we: 1'b1, addr: d, data: va | vb};
            OP_NOR:  rf_wr = '{we: 1'b1, addr: d, data: ~(va | vb)};
            OP_NOTB: rf_wr = '{we: 1'b1, addr: d, data: ~va};
            OP_SAL:  rf_wr = '{we: 1'b1, addr: d, data: sal_r};
            OP_SAR:  rf_wr = '{we: 1'b1, addr: d, data: sar_r};
            OP_EQU:  cy_next = vd == va;
            OP_LT:   cy_next = $signed(vd) < $signed(va);
            OP_LTE:  cy_next = $signed(vd) <= $signed(va);
            OP_NOTC: cy_next = !cy;
            default: ;
          endcase
        end
      end

      S_MEM: begin
        dm_ra = ea_q;
        dm_wa = ea_q;
        dm_wd = vd[15:8];
        pc_next    = pc4;
        state_next = S_DONE;
        unique case (op)
          OP_POP:    rf_wr = '{we: 1'b1, addr: d, data: ws_q};
          OP_LOADB:  rf_wr = '{we: 1'b1, addr: d, data: {8'h00, dm_q}};
          OP_STOREW: dm_we = 1'b1;
          default: begin
            // word load: low byte first, then high byte
            if (cnt == '0) begin
              lo_next    = dm_q;
              cnt_next   = 4'd1;
              pc_next    = pc;
              state_next = S_MEM;
            end else begin
              rf_wr = '{we: 1'b1, addr: d, data: {dm_q, lo}};
            end
          end
        endcase
      end

      S_DIV: begin
        if (div_res.done) begin
          ovf_next   = div_res.ovf;
          rf_wr      = '{we: 1'b1, addr: d, data: div_res.quo};
          pc_next    = pc4;
          state_next = S_DONE;
        end
      end

      S_CALL: begin
        // read register cnt, store register cnt-1 into the frame
        rf_ra    = cnt[2:0];
        fr_we    = cnt != '0;
        cnt_next = cnt + 1'b1;
        if (cnt == 4'd8) begin
          ft_next    = ft + 1'b1;
          pc_next    = addr;
          state_next = S_DONE;
        end
      end

      S_RET: begin
        // frame pointer already points at the frame being restored
        fp_ra    = ft[FA-1:0];
        rf_wr    = '{we: cnt != '0, addr: 3'(cnt - 1'b1), data: fr_q};
        cnt_next = cnt + 1'b1;
        if (cnt == 4'd8) begin
          ovf_next     = fp_q[PC_W];
          cy_next      = fp_q[PC_W+1];
          pc_next      = fp_q[PC_W-1:0] + PC_W'(4);
          res_npc_next = fp_q[PC_W-1:0] + PC_W'(4);
          state_next   = S_DONE;
        end
      end

      S_DONE: begin
        if (!o_valid || out_ch.ready) begin
          o_load     = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  assign o_valid_next = o_load || (o_valid && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      pc      <= '0;
      ovf     <= 1'b0;
      cy      <= 1'b0;
      halted  <= 1'b0;
      wt      <= '0;
      ft      <= '0;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      pc      <= pc_next;
      ovf     <= ovf_next;
      cy      <= cy_next;
      halted  <= halted_next;
      wt      <= wt_next;
      ft      <= ft_next;
      o_valid <= o_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ir         <= ir_next;
    inch       <= inch_next;
    vd         <= vd_next;
    va         <= va_next;
    vb         <= vb_next;
    vg         <= vg_next;
    ea_q       <= ea_q_next;
    lo         <= lo_next;
    res_status <= res_status_next;
    res_npc    <= res_npc_next;
    res_ov     <= res_ov_next;
    res_oc     <= res_oc_next;
    if (o_load) begin
      o_status <= res_status;
      o_npc    <= res_npc;
      o_ov     <= res_ov;
      o_oc     <= res_oc;
    end
  end

  assign in_ch.ready      = state == S_IDLE;
  assign out_ch.valid     = o_valid;
  assign out_ch.status    = o_status;
  assign out_ch.next_pc   = o_npc;
  assign out_ch.out_valid = o_ov;
  assign out_ch.out_char  = o_oc;

  // halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted) else $error("halt flag cleared");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    wt <= STW'(STACK_WORDS)) else $error("word stack pointer out of range");

  a_frame_bound: assert property (@(posedge clk) disable iff (rst)
    ft <= FTW'(CALL_FRAMES)) else $error("frame pointer out of range");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> state == S_DIV) else $error("divider finished outside divide");

endmodule

// ----- bench/tb_sixteen_bit_instruction_executor_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sixteen_bit_instruction_executor_top
// Self-checking bench for the 16-bit instruction executor. A behavioral
// machine model in the bench predicts status, next PC and port output for
// every accepted request. Directed checks cover the arithmetic extremes, the
// flags, the stacks and memory access. Random programs are filtered so that
// they keep running. One faulting or halting instruction ends the run.
// ----------------------------------------------------------------------------
module tb_sixteen_bit_instruction_executor_top;
  import sbie_pkg::*;

  typedef struct {
    logic        func;
    logic [31:0] instr;
    logic [8:0]  in_char;
    logic [15:0] mem_addr;
    logic [7:0]  mem_byte;
  } req_t;

  typedef struct {
    status_t     status;
    logic [23:0] npc;
    logic        ov;
    logic [7:0]  oc;
  } res_t;

  logic clk;
  logic rst;
  sbie_in_if  in_ch();
  sbie_out_if out_ch();

  sixteen_bit_instruction_executor_top DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // machine state mirrored by the bench
  logic [15:0] regs [8];
  logic [23:0] pc;
  logic        ovf_flag, carry, stopped;
  logic [7:0]  dmem [65536];
  bit          dknown [65536];
  logic [15:0] wstk [STACK_WORDS_DEF];
  int          wtop;
  logic [15:0] fregs [CALL_FRAMES_DEF*8];
  logic [23:0] fpc [CALL_FRAMES_DEF];
  logic [1:0]  fflg [CALL_FRAMES_DEF];
  int          ftop;

  res_t expected_results[$];
  int   errors = 0;
  bit   quiet = 0;
  int   hold_cycles = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

  function automatic int sx(input logic [15:0] v);
    return int'($signed(v));
  endfunction

  function automatic int shift_amount(input logic [15:0] v);
    int s;
    s = sx(v);
    if (s < 0) return 0;
    if (s > 15) return 15;
    return s;
  endfunction

  // Execute one instruction word; state changes only when commit is set.
  // blind flags a read of data memory that was never written.
  function automatic status_t exec_instr(input logic [31:0] ir, input logic [8:0] ch,
                                         input bit commit, output logic [23:0] npc,
                                         output logic ov, output logic [7:0] oc,
                                         output bit blind);
    op_t         op;
    logic [2:0]  d;
    logic [3:0]  r1, r2;
    logic [23:0] adr;
    logic [15:0] imm, a, b, res;
    logic [7:0]  port;
    longint      ea;
    int          r;
    bit          wr, fo, fc, of, nc;
    op = ir[31:27];
    d = ir[26:24];
    r1 = ir[23:20];
    r2 = ir[19:16];
    adr = ir[23:0];
    imm = ir[15:0];
    port = ir[7:0];
    npc = pc + 24'd4;
    ov = 0;
    oc = 0;
    blind = 0;
    wr = 0;
    fo = 0;
    fc = 0;
    of = 0;
    nc = 0;
    res = 0;
    if ((op == OP_POP || op == OP_LOADW || op == OP_LOADI || op == OP_IN ||
         (op >= OP_ADD && op <= OP_SAR)) && d == 0)
      return ST_ZDEST;
    if ((op == OP_ADD || op == OP_SUB || (op >= OP_MUL && op <= OP_NOR) ||
         op == OP_SAL || op == OP_SAR) && (r1 > 7 || r2 > 7))
      return ST_BADREG;
    if ((op == OP_NOTB || (op >= OP_EQU && op <= OP_LTE)) && r1 > 7)
      return ST_BADREG;
    a = regs[r1[2:0]];
    b = regs[r2[2:0]];
    case (op)
      OP_HLT: return ST_HALT;
      OP_JMP: npc = adr;
      OP_CJMP: if (carry) npc = adr;
      OP_OJMP: if (ovf_flag) npc = adr;
      OP_CALL: begin
        if (ftop >= CALL_FRAMES_DEF) return ST_FRAME;
        if (commit) begin
          for (int i = 0; i < 8; i++) fregs[ftop*8+i] = regs[i];
          fpc[ftop] = pc;
          fflg[ftop] = {carry, ovf_flag};
          ftop++;
        end
        npc = adr;
      end
      OP_RET: begin
        if (ftop == 0) return ST_HALT;
        npc = fpc[ftop-1] + 24'd4;
        if (commit) begin
          ftop--;
          for (int i = 0; i < 8; i++) regs[i] = fregs[ftop*8+i];
          ovf_flag = fflg[ftop][0];
          carry = fflg[ftop][1];
        end
      end
      OP_PUSH: begin
        if (wtop >= STACK_WORDS_DEF) return ST_OVF;
        if (commit) begin
          wstk[wtop] = regs[d];
          wtop++;
        end
      end
      OP_POP: begin
        if (wtop == 0) return ST_UNDER;
        if (commit) begin
          wtop--;
          regs[d] = wstk[wtop];
        end
      end
      OP_LOADB, OP_STOREB: begin
        ea = longint'(adr) + sx(regs[7]);
        if (ea < 0 || ea >= DATA_DEPTH_DEF) return ST_RANGE;
        if (op == OP_LOADB) begin
          blind = !dknown[ea];
          if (commit) regs[d] = {8'h00, dmem[ea]};
        end else if (commit) begin
          dmem[ea] = regs[d][7:0];
          dknown[ea] = 1;
        end
      end
      OP_LOADW, OP_STOREW: begin
        ea = longint'(adr) + 2 * sx(regs[7]);
        if (ea < 0 || ea + 1 >= DATA_DEPTH_DEF) return ST_RANGE;
        if (op == OP_LOADW) begin
          blind = !dknown[ea] || !dknown[ea+1];
          if (commit) regs[d] = {dmem[ea+1], dmem[ea]};
        end else if (commit) begin
          dmem[ea] = regs[d][7:0];
          dmem[ea+1] = regs[d][15:8];
          dknown[ea] = 1;
          dknown[ea+1] = 1;
        end
      end
      OP_LOADI: begin
        res = imm;
        wr = 1;
      end
      OP_NOP: ;
      OP_IN: begin
        if (port != PORT_IN) return ST_PORT;
        res = ch[8] ? {8'hff, ch[7:0]} : {8'h00, ch[7:0]};
        wr = 1;
      end
      OP_OUT: begin
        if (port != PORT_OUT) return ST_PORT;
        ov = 1;
        oc = regs[d][7:0];
      end
      OP_ADD, OP_ADDI, OP_SUB, OP_SUBI, OP_MUL, OP_DIV: begin
        case (op)
          OP_ADD: r = sx(a) + sx(b);
          OP_ADDI: r = sx(regs[d]) + int'(imm);
          OP_SUB: r = sx(a) - sx(b);
          OP_SUBI: r = sx(regs[d]) - int'(imm);
          OP_MUL: r = sx(a) * sx(b);
          default: begin
            if (b == 0) return ST_DIV0;
            r = sx(a) / sx(b);
          end
        endcase
        res = r[15:0];
        wr = 1;
        fo = 1;
        of = (r < -32768 || r > 32767);
      end
      OP_AND: begin res = a & b; wr = 1; end
      OP_OR: begin res = a | b; wr = 1; end
      OP_NOR: begin res = ~(a | b); wr = 1; end
      OP_NOTB: begin res = ~a; wr = 1; end
      OP_SAL: begin res = a << shift_amount(b); wr = 1; end
      OP_SAR: begin res = $signed(a) >>> shift_amount(b); wr = 1; end
      OP_EQU: begin nc = (regs[d] == a); fc = 1; end
      OP_LT: begin nc = (sx(regs[d]) < sx(a)); fc = 1; end
      OP_LTE: begin nc = (sx(regs[d]) <= sx(a)); fc = 1; end
      default: begin nc = !carry; fc = 1; end
    endcase
    if (commit) begin
      if (wr) regs[d] = res;
      if (fo) ovf_flag = of;
      if (fc) carry = nc;
    end
    return ST_OK;
  endfunction

  function automatic res_t predict_result(input req_t q);
    res_t e;
    bit   bl;
    e.status = ST_OK;
    e.npc = pc;
    e.ov = 0;
    e.oc = 0;
    if (q.func) begin
      dmem[q.mem_addr] = q.mem_byte;
      dknown[q.mem_addr] = 1;
    end else if (stopped) begin
      e.status = ST_STOPPED;
    end else begin
      e.status = exec_instr(q.instr, q.in_char, 1, e.npc, e.ov, e.oc, bl);
      if (e.status == ST_OK) begin
        pc = e.npc;
      end else if (e.status == ST_HALT) begin
        stopped = 1;
        pc = e.npc;
      end else begin
        stopped = 1;
        e.npc = pc;
        e.ov = 0;
        e.oc = 0;
      end
    end
    return e;
  endfunction

  function automatic req_t preload(input logic [15:0] ad, input logic [7:0] v);
    req_t q;
    q.func = 1;
    q.instr = $urandom;
    q.in_char = 0;
    q.mem_addr = ad;
    q.mem_byte = v;
    return q;
  endfunction

  function automatic req_t instr_req(input logic [31:0] ir, input logic [8:0] ch = 9'd0);
    req_t q;
    q.func = 0;
    q.instr = ir;
    q.in_char = ch;
    q.mem_addr = $urandom;
    q.mem_byte = $urandom;
    return q;
  endfunction

  function automatic logic [31:0] mk(input op_t op, input logic [2:0] d,
                                     input logic [3:0] r1, input logic [3:0] r2,
                                     input logic [15:0] imm);
    return {op, d, r1, r2, imm};
  endfunction

  // Draw a request that keeps the machine running and reads only written memory.
  function automatic req_t random_req();
    req_t        q;
    op_t         op;
    logic [23:0] n;
    logic        o;
    logic [7:0]  c;
    bit          bl;
    status_t     s;
    q = instr_req($urandom, ($urandom_range(0, 15) == 0) ? 9'h1ff : {1'b0, 8'($urandom)});
    if ($urandom_range(0, 9) == 0) begin
      q.func = 1;
      if ($urandom_range(0, 1)) q.mem_addr = $urandom_range(0, 600);
      return q;
    end
    for (int t = 0; t < 64; t++) begin
      op = $urandom_range(0, 31);
      q.instr = $urandom;
      q.instr[31:27] = op;
      case (op)
        OP_LOADB, OP_LOADW, OP_STOREB, OP_STOREW: q.instr[23:0] = $urandom_range(0, 600);
        OP_IN: q.instr[7:0] = PORT_IN;
        OP_OUT: q.instr[7:0] = PORT_OUT;
        default: if (op >= OP_ADD) begin
          q.instr[23] = 0;
          q.instr[19] = 0;
        end
      endcase
      // keep G small so indexed accesses land in range
      if ($urandom_range(0, 7) == 0)
        q.instr = mk(OP_LOADI, 3'd7, 4'($urandom), 4'($urandom),
                     16'($urandom_range(0, 300)) - 16'd100);
      s = exec_instr(q.instr, q.in_char, 0, n, o, c, bl);
      if (s == ST_OK && !bl) return q;
    end
    q.instr = {OP_NOP, 27'($urandom)};
    return q;
  endfunction

  task automatic send_req(input req_t q);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1;
    in_ch.func     <= q.func;
    in_ch.instr    <= q.instr;
    in_ch.in_char  <= q.in_char;
    in_ch.mem_addr <= q.mem_addr;
    in_ch.mem_byte <= q.mem_byte;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(predict_result(q));
    @(negedge clk);
  endtask

  task automatic test_directed();
    send_req(preload(16'h0000, 8'ha5));
    send_req(preload(16'hffff, 8'h5a));
    send_req(preload(16'h0001, 8'h3c));
    send_req(instr_req(mk(OP_LOADI, 3'd1, 0, 0, 16'h7fff)));
    send_req(instr_req(mk(OP_LOADI, 3'd2, 0, 0, 16'h8000)));
    send_req(instr_req(mk(OP_ADD, 3'd3, 4'd1, 4'd1, 0)));
    send_req(instr_req({OP_OJMP, 3'd0, 24'hffffff}));
    send_req(instr_req(mk(OP_NOP, 0, 0, 0, 0)));      // PC wraps past the top
    send_req(instr_req(mk(OP_SUB, 3'd4, 4'd2, 4'd1, 0)));
    send_req(instr_req(mk(OP_MUL, 3'd5, 4'd2, 4'd2, 0)));
    send_req(instr_req(mk(OP_LOADI, 3'd6, 0, 0, 16'hffff)));
    send_req(instr_req(mk(OP_DIV, 3'd5, 4'd2, 4'd6, 0)));
    send_req(instr_req(mk(OP_ADDI, 3'd1, 0, 0, 16'hffff)));
    send_req(instr_req(mk(OP_SUBI, 3'd2, 0, 0, 16'hffff)));
    send_req(instr_req(mk(OP_NOR, 3'd3, 4'd1, 4'd2, 0)));
    send_req(instr_req(mk(OP_NOTB, 3'd4, 4'd1, 0, 0)));
    send_req(instr_req(mk(OP_SAL, 3'd3, 4'd6, 4'd6, 0)));   // negative amount
    send_req(instr_req(mk(OP_SAR, 3'd4, 4'd6, 4'd1, 0)));   // oversized amount
    send_req(instr_req(mk(OP_LOADI, 3'd7, 0, 0, 16'hffff)));
    send_req(instr_req(mk(OP_LOADB, 3'd0, 0, 0, 16'h0001)));
    send_req(instr_req(mk(OP_STOREW, 3'd1, 0, 0, 16'h0002)));
    send_req(instr_req(mk(OP_LOADW, 3'd3, 0, 0, 16'h0002)));
    send_req(instr_req({OP_CALL, 3'd0, 24'h000100}));
    send_req(instr_req(mk(OP_PUSH, 3'd1, 0, 0, 0)));
    send_req(instr_req(mk(OP_POP, 3'd2, 0, 0, 0)));
    send_req(instr_req(mk(OP_RET, 0, 0, 0, 0)));
    send_req(instr_req(mk(OP_EQU, 3'd1, 4'd1, 0, 0)));
    send_req(instr_req({OP_CJMP, 3'd0, 24'h800000}));
    send_req(instr_req(mk(OP_LT, 3'd2, 4'd1, 0, 0)));
    send_req(instr_req(mk(OP_LTE, 3'd2, 4'd2, 0, 0)));
    send_req(instr_req(mk(OP_NOTC, 0, 0, 0, 0)));
    send_req(instr_req(mk(OP_IN, 3'd5, 0, 0, {8'h00, PORT_IN}), 9'h1ff));
    send_req(instr_req(mk(OP_OUT, 3'd5, 0, 0, {8'h00, PORT_OUT})));
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 300 == 0) quiet = ($urandom_range(0, 2) == 0);
      send_req(random_req());
    end
    quiet = 0;
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    quiet = 1;
    for (int i = 0; i < 12; i++) send_req(random_req());
    quiet = 0;
  endtask

  // One faulting or halting instruction, then requests against a halted machine.
  task automatic test_halt();
    req_t        q;
    logic [23:0] n;
    logic        o;
    logic [7:0]  c;
    bit          bl;
    status_t     s;
    do begin
      q = instr_req($urandom, 9'($urandom));
      s = exec_instr(q.instr, q.in_char, 0, n, o, c, bl);
    end while (s == ST_OK || bl);
    send_req(q);
    send_req(instr_req($urandom));
    send_req(preload(16'($urandom), 8'($urandom)));
    send_req(instr_req(mk(OP_NOP, 0, 0, 0, 0)));
  endtask

  // result receiver with random stalls
  initial begin
    int stall;
    out_ch.ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 19);
      end
      if (stall > 0) begin
        out_ch.ready <= 0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    res_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d next_pc=%h", $time,
                 out_ch.status, out_ch.next_pc);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_ch.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_ch.status);
          errors++;
        end
        if (out_ch.next_pc !== e.npc) begin
          $display("%0t: next_pc expected %h actual %h", $time, e.npc, out_ch.next_pc);
          errors++;
        end
        if (out_ch.out_valid !== e.ov) begin
          $display("%0t: out_valid expected %0d actual %0d", $time, e.ov, out_ch.out_valid);
          errors++;
        end
        if (out_ch.out_char !== e.oc) begin
          $display("%0t: out_char expected %h actual %h", $time, e.oc, out_ch.out_char);
          errors++;
        end
      end
    end
  end

  initial begin
    int waited;
    for (int i = 0; i < 8; i++) regs[i] = 0;
    pc = 0;
    ovf_flag = 0;
    carry = 0;
    stopped = 0;
    wtop = 0;
    ftop = 0;
    rst = 1;
    in_ch.valid = 0;
    in_ch.func = 0;
    in_ch.instr = 0;
    in_ch.in_char = 0;
    in_ch.mem_addr = 0;
    in_ch.mem_byte = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed();
    test_random(800);
    test_backpressure();
    test_random(950);
    test_halt();
    in_ch.valid <= 0;
    waited = 0;
    while (expected_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ----- sixteen_bit_instruction_executor_top.f -----
rtl/sbie_pkg.sv
rtl/sbie_if.sv
rtl/sbie_rf.sv
rtl/sbie_div.sv
rtl/sixteen_bit_instruction_executor_top.sv
bench/tb_sixteen_bit_instruction_executor_top.sv
